// ===== design/rdrc_pkg.sv =====
// Package: request/result types, opcodes, status codes and FSM states for the dedupe cache.
`timescale 1ns / 1ps
package rdrc_pkg;
	localparam int PendingDepthDef = 8;
	localparam int CacheDepthDef = 16;

	typedef enum logic [2:0] {
		OP_RECEIVE = 3'd0,
		OP_CAN_COMMIT = 3'd1,
		OP_FINISH = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_NEW = 4'd1,
		ST_BAD_ARG = 4'd2,
		ST_BAD_STATE = 4'd3,
		ST_MISMATCH = 4'd4,
		ST_DUP_PENDING = 4'd5,
		ST_DUP_CACHED = 4'd6,
		ST_STALE = 4'd7,
		ST_BUSY = 4'd8,
		ST_EXPIRED = 4'd9,
		ST_NOT_FOUND = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_P,
		S_SCAN_C,
		S_EXEC,
		S_CLEAR,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_SESSION_OPEN = 2'd0,
		REG_SESSION_PEER = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [31:0] peer_id;
		logic [31:0] msg_key;
		logic has_side_effect;
		logic [15:0] deadline_span;
		logic [63:0] now_time;
		logic signed [31:0] result_value;
		logic [31:0] owner_word;
	} req_t;

	typedef struct packed {
		logic [3:0] status;
		logic signed [31:0] cached_result_value;
		logic [31:0] cached_owner_word;
		logic [3:0] pending_count;
	} rsp_t;
endpackage

// ===== design/request_dedupe_result_cache_top.sv =====
// Top level: request dedupe tracker with pending table and round-robin result cache.
//
// Usage: one request enters on req (valid/ready) and yields exactly one response
// on rsp (valid/ready). The block holds one request at a time: after accept it
// walks the pending table one entry a cycle, then the result cache one entry a
// cycle, through a single shared id comparator, then applies the update in
// S_EXEC; a clear request walks both stores one entry a cycle instead.
// req_ready is high only while idle with no response waiting; the response
// register holds until the receiver takes it, and the next request is accepted
// only after that, so a new request never enters before the last one's
// response is taken. Configuration writes (cfg_we, cfg_idx, cfg_data)
// take effect on the next edge and should only come while idle.
// Reset clears all valid bits, the victim pointer, highest id and session
// registers at once; no clearing pass is needed after reset.
`timescale 1ns / 1ps
module request_dedupe_result_cache_top import rdrc_pkg::*; #(
	parameter int PENDING_DEPTH = PendingDepthDef,
	parameter int CACHE_DEPTH = CacheDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp,
	input logic cfg_we,
	input logic cfg_idx,
	input logic [31:0] cfg_data
);
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int NW = $clog2(PENDING_DEPTH + 1);
	localparam int ND = (PENDING_DEPTH > CACHE_DEPTH) ? PENDING_DEPTH : CACHE_DEPTH;
	localparam int IW = (ND > 1) ? $clog2(ND) : 1;

	state_t state_q, state_d;
	req_t req_q;
	logic session_open_q;
	logic [31:0] session_peer_q;

	logic [PENDING_DEPTH-1:0] p_used_q;
	logic [31:0] p_id_q [PENDING_DEPTH];
	logic [63:0] p_dl_q [PENDING_DEPTH];
	logic [CACHE_DEPTH-1:0] c_used_q;
	logic [31:0] c_id_q [CACHE_DEPTH];
	logic [31:0] c_res_q [CACHE_DEPTH];
	logic [31:0] c_own_q [CACHE_DEPTH];
	logic [CW-1:0] victim_q;
	logic [31:0] highest_q;
	logic highest_vld_q;
	logic [NW-1:0] count_q;

	logic [IW-1:0] idx_q;
	logic p_hit_q, c_hit_q, free_fnd_q;
	logic [PW-1:0] p_idx_q, free_idx_q;
	logic [63:0] p_dl_hit_q;
	logic [31:0] c_res_hit_q, c_own_hit_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// shared id comparator
	logic [31:0] cmp_a;
	logic id_eq;
	logic [PW-1:0] pidx;
	logic [CW-1:0] cidx;
	logic p_last, c_last, clr_last;

	assign pidx = idx_q[PW-1:0];
	assign cidx = idx_q[CW-1:0];
	assign cmp_a = (state_q == S_SCAN_P) ? p_id_q[pidx] : c_id_q[cidx];
	assign id_eq = (cmp_a == req_q.msg_key);
	assign p_last = (idx_q == IW'(PENDING_DEPTH - 1));
	assign c_last = (idx_q == IW'(CACHE_DEPTH - 1));
	assign clr_last = (idx_q == IW'(ND - 1));

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid && req_ready)
				state_d = (req.opcode == OP_CLEAR) ? S_CLEAR : S_SCAN_P;
			S_SCAN_P: if (p_last) state_d = S_SCAN_C;
			S_SCAN_C: if (c_last) state_d = S_EXEC;
			S_EXEC: state_d = S_DONE;
			S_CLEAR: if (clr_last) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_open_q <= 1'b0;
			session_peer_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_SESSION_OPEN[0]) session_open_q <= cfg_data[0];
			else session_peer_q <= cfg_data;
		end
	end

	// exec decision
	status_t st;
	logic do_ins, do_fin;
	always_comb begin
		st = ST_BAD_ARG;
		do_ins = 1'b0;
		do_fin = 1'b0;
		case (req_q.opcode)
			OP_RECEIVE: begin
				if (!session_open_q) st = ST_BAD_STATE;
				else if (req_q.peer_id != session_peer_q) st = ST_MISMATCH;
				else if (p_hit_q) st = ST_DUP_PENDING;
				else if (c_hit_q) st = ST_DUP_CACHED;
				else if (highest_vld_q && req_q.msg_key <= highest_q) st = ST_STALE;
				else if (req_q.has_side_effect && req_q.deadline_span == '0) st = ST_BAD_ARG;
				else if (req_q.has_side_effect && !free_fnd_q) st = ST_BUSY;
				else begin
					st = ST_NEW;
					do_ins = req_q.has_side_effect;
				end
			end
			OP_CAN_COMMIT: begin
				if (!p_hit_q) st = ST_STALE;
				else if (req_q.now_time >= p_dl_hit_q) st = ST_EXPIRED;
				else st = ST_OK;
			end
			OP_FINISH: begin
				if (!p_hit_q) st = ST_STALE;
				else begin
					st = ST_OK;
					do_fin = 1'b1;
				end
			end
			OP_LOOKUP: st = c_hit_q ? ST_OK : ST_NOT_FOUND;
			OP_CLEAR: st = ST_OK;
			default: st = ST_BAD_ARG;
		endcase
	end

	logic rcv_ok;
	assign rcv_ok = (req_q.opcode == OP_RECEIVE) && (st == ST_NEW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_used_q <= '0;
			c_used_q <= '0;
			victim_q <= '0;
			highest_q <= '0;
			highest_vld_q <= 1'b0;
			count_q <= '0;
			idx_q <= '0;
			p_hit_q <= 1'b0;
			c_hit_q <= 1'b0;
			free_fnd_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					p_hit_q <= 1'b0;
					c_hit_q <= 1'b0;
					free_fnd_q <= 1'b0;
				end
				S_SCAN_P: begin
					if (!p_hit_q && p_used_q[pidx] && id_eq) begin
						p_hit_q <= 1'b1;
						p_idx_q <= pidx;
						p_dl_hit_q <= p_dl_q[pidx];
					end
					if (!free_fnd_q && !p_used_q[pidx]) begin
						free_fnd_q <= 1'b1;
						free_idx_q <= pidx;
					end
					idx_q <= p_last ? '0 : idx_q + 1'b1;
				end
				S_SCAN_C: begin
					if (!c_hit_q && c_used_q[cidx] && id_eq) begin
						c_hit_q <= 1'b1;
						c_res_hit_q <= c_res_q[cidx];
						c_own_hit_q <= c_own_q[cidx];
					end
					idx_q <= c_last ? '0 : idx_q + 1'b1;
				end
				S_EXEC: begin
					if (do_ins) begin
						p_used_q[free_idx_q] <= 1'b1;
						count_q <= count_q + 1'b1;
					end
					if (rcv_ok) begin
						highest_q <= req_q.msg_key;
						highest_vld_q <= 1'b1;
					end
					if (do_fin) begin
						p_used_q[p_idx_q] <= 1'b0;
						c_used_q[victim_q] <= 1'b1;
						victim_q <= (victim_q == CW'(CACHE_DEPTH - 1)) ? '0 : victim_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
					rsp_q.status <= st;
					rsp_q.cached_result_value <= (req_q.opcode == OP_LOOKUP && c_hit_q)
						? c_res_hit_q : '0;
					rsp_q.cached_owner_word <= (req_q.opcode == OP_LOOKUP && c_hit_q)
						? c_own_hit_q : '0;
					rsp_q.pending_count <= 4'(do_ins ? count_q + 1'b1
						: (do_fin ? count_q - 1'b1 : count_q));
				end
				S_CLEAR: begin
					// one entry of each store per cycle
					if (int'(idx_q) < PENDING_DEPTH) p_used_q[pidx] <= 1'b0;
					if (int'(idx_q) < CACHE_DEPTH) c_used_q[cidx] <= 1'b0;
					idx_q <= idx_q + 1'b1;
					if (clr_last) begin
						victim_q <= '0;
						highest_q <= '0;
						highest_vld_q <= 1'b0;
						count_q <= '0;
						rsp_q.status <= ST_OK;
						rsp_q.cached_result_value <= '0;
						rsp_q.cached_owner_word <= '0;
						rsp_q.pending_count <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload stores, no reset
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
		if (state_q == S_EXEC && do_ins) begin
			p_id_q[free_idx_q] <= req_q.msg_key;
			p_dl_q[free_idx_q] <= req_q.now_time + 64'(req_q.deadline_span);
		end
		if (state_q == S_EXEC && do_fin) begin
			c_id_q[victim_q] <= req_q.msg_key;
			c_res_q[victim_q] <= req_q.result_value;
			c_own_q[victim_q] <= req_q.owner_word;
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (count_q == NW'($countones(p_used_q))))
		else $error("pending count out of step with used bits");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !req_ready)
		else $error("request accepted while a response waits");
	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		victim_q <= CW'(CACHE_DEPTH - 1))
		else $error("victim out of range");
endmodule
